[rtl/position_velocity_bias_kalman_top_defines.svh]
// Assertion helpers for the Kalman filter block.
`ifndef POSITION_VELOCITY_BIAS_KALMAN_TOP_DEFINES_SVH
`define POSITION_VELOCITY_BIAS_KALMAN_TOP_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define PVBK_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define PVBK_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define PVBK_ASSERT_NOW(label, clk, rst, ante, cons)
`define PVBK_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[rtl/pvbk_pkg.sv]
package pvbk_pkg;

   localparam logic [47:0] FX_MAX = 48'h7FFF_FFFF_FFFF;
   localparam logic [47:0] FX_MIN = 48'h8000_0000_0000;
   localparam logic [47:0] FX_ONE = 48'h0001_0000_0000;

   // ALU operation codes
   localparam logic [2:0] OP_ADD  = 3'd0;
   localparam logic [2:0] OP_SUB  = 3'd1;
   localparam logic [2:0] OP_MUL  = 3'd2;
   localparam logic [2:0] OP_HALF = 3'd3;
   localparam logic [2:0] OP_NEG  = 3'd4;
   localparam logic [2:0] OP_DIV  = 3'd5;

   // operand space: 0..31 scratch RAM, 32 and up fixed sources
   localparam logic [5:0] A_POS  = 6'd0;
   localparam logic [5:0] A_VEL  = 6'd1;
   localparam logic [5:0] A_BIAS = 6'd2;
   localparam logic [5:0] A_P0   = 6'd3;
   localparam logic [5:0] A_P1   = 6'd4;
   localparam logic [5:0] A_P2   = 6'd5;
   localparam logic [5:0] A_P3   = 6'd6;
   localparam logic [5:0] A_P4   = 6'd7;
   localparam logic [5:0] A_P5   = 6'd8;
   localparam logic [5:0] A_P6   = 6'd9;
   localparam logic [5:0] A_P7   = 6'd10;
   localparam logic [5:0] A_P8   = 6'd11;
   localparam logic [5:0] A_T0   = 6'd12;
   localparam logic [5:0] A_T1   = 6'd13;
   localparam logic [5:0] A_T2   = 6'd14;
   localparam logic [5:0] A_T3   = 6'd15;
   localparam logic [5:0] A_H    = 6'd16;
   localparam logic [5:0] A_D0   = 6'd17;
   localparam logic [5:0] A_D1   = 6'd18;
   localparam logic [5:0] A_D2   = 6'd19;
   localparam logic [5:0] A_D3   = 6'd20;
   localparam logic [5:0] A_D4   = 6'd21;
   localparam logic [5:0] A_D5   = 6'd22;
   localparam logic [5:0] A_D6   = 6'd23;
   localparam logic [5:0] A_PC0  = 6'd24;
   localparam logic [5:0] A_PC1  = 6'd25;
   localparam logic [5:0] A_PC2  = 6'd26;
   localparam logic [5:0] A_E    = 6'd27;
   localparam logic [5:0] A_K0   = 6'd28;
   localparam logic [5:0] A_K1   = 6'd29;
   localparam logic [5:0] A_K2   = 6'd30;
   localparam logic [5:0] A_ERR  = 6'd31;
   localparam logic [5:0] S_DT   = 6'd32;
   localparam logic [5:0] S_C    = 6'd33;
   localparam logic [5:0] S_QP   = 6'd34;
   localparam logic [5:0] S_QV   = 6'd35;
   localparam logic [5:0] S_QB   = 6'd36;
   localparam logic [5:0] S_R    = 6'd37;
   localparam logic [5:0] S_Z    = 6'd38;
   localparam logic [5:0] S_ACC  = 6'd39;

   localparam int RF_DEPTH = 32;
   localparam int STATE_WORDS = 12;     // pos, vel, bias, P0..P8
   localparam logic [6:0] PC_LAST = 7'd87;

   typedef struct packed {
      logic [2:0] op;
      logic [5:0] dst;
      logic [5:0] src_a;
      logic [5:0] src_b;
   } ucode_type;

   typedef struct packed {
      logic       start;
      logic [2:0] op;
   } alu_req_type;

   function automatic ucode_type mk(input logic [2:0] op, input logic [5:0] dst,
                                    input logic [5:0] a, input logic [5:0] b);
      ucode_type u;
      u.op = op;
      u.dst = dst;
      u.src_a = a;
      u.src_b = b;
      return u;
   endfunction

   // filter step microprogram
   function automatic ucode_type ucode(input logic [6:0] pc);
      ucode_type u;
      unique case (pc)
         // state prediction
         7'd0:  u = mk(OP_SUB,  A_T0,   S_ACC,  A_BIAS);
         7'd1:  u = mk(OP_MUL,  A_T1,   A_T0,   S_DT);
         7'd2:  u = mk(OP_ADD,  A_VEL,  A_VEL,  A_T1);
         7'd3:  u = mk(OP_MUL,  A_T2,   A_T1,   S_DT);
         7'd4:  u = mk(OP_HALF, A_T2,   A_T2,   A_T2);
         7'd5:  u = mk(OP_MUL,  A_T3,   A_VEL,  S_DT);
         7'd6:  u = mk(OP_ADD,  A_T2,   A_T2,   A_T3);
         7'd7:  u = mk(OP_ADD,  A_POS,  A_POS,  A_T2);
         // covariance derivative
         7'd8:  u = mk(OP_ADD,  A_T0,   S_QP,   A_P1);
         7'd9:  u = mk(OP_ADD,  A_T0,   A_T0,   A_P3);
         7'd10: u = mk(OP_HALF, A_T1,   A_P6,   A_P6);
         7'd11: u = mk(OP_SUB,  A_T1,   A_P4,   A_T1);
         7'd12: u = mk(OP_HALF, A_T2,   A_P2,   A_P2);
         7'd13: u = mk(OP_SUB,  A_T1,   A_T1,   A_T2);
         7'd14: u = mk(OP_MUL,  A_T1,   A_T1,   S_DT);
         7'd15: u = mk(OP_ADD,  A_D0,   A_T0,   A_T1);
         7'd16: u = mk(OP_SUB,  A_T0,   A_P4,   A_P2);
         7'd17: u = mk(OP_HALF, A_T1,   A_P7,   A_P7);
         7'd18: u = mk(OP_ADD,  A_T1,   A_T1,   A_P5);
         7'd19: u = mk(OP_MUL,  A_T1,   A_T1,   S_DT);
         7'd20: u = mk(OP_SUB,  A_D1,   A_T0,   A_T1);
         7'd21: u = mk(OP_MUL,  A_T0,   A_P8,   S_DT);
         7'd22: u = mk(OP_HALF, A_H,    A_T0,   A_T0);
         7'd23: u = mk(OP_SUB,  A_D2,   A_P5,   A_H);
         7'd24: u = mk(OP_SUB,  A_T0,   A_P4,   A_P6);
         7'd25: u = mk(OP_HALF, A_T1,   A_P5,   A_P5);
         7'd26: u = mk(OP_ADD,  A_T1,   A_P7,   A_T1);
         7'd27: u = mk(OP_MUL,  A_T1,   A_T1,   S_DT);
         7'd28: u = mk(OP_SUB,  A_D3,   A_T0,   A_T1);
         7'd29: u = mk(OP_SUB,  A_T0,   S_QV,   A_P7);
         7'd30: u = mk(OP_SUB,  A_T0,   A_T0,   A_P5);
         7'd31: u = mk(OP_MUL,  A_T1,   A_P8,   S_DT);
         7'd32: u = mk(OP_ADD,  A_D4,   A_T0,   A_T1);
         7'd33: u = mk(OP_NEG,  A_D5,   A_P8,   A_P8);
         7'd34: u = mk(OP_SUB,  A_D6,   A_P7,   A_H);
         // Euler step
         7'd35: u = mk(OP_MUL,  A_T0,   A_D0,   S_DT);
         7'd36: u = mk(OP_ADD,  A_P0,   A_P0,   A_T0);
         7'd37: u = mk(OP_MUL,  A_T0,   A_D1,   S_DT);
         7'd38: u = mk(OP_ADD,  A_P1,   A_P1,   A_T0);
         7'd39: u = mk(OP_MUL,  A_T0,   A_D2,   S_DT);
         7'd40: u = mk(OP_ADD,  A_P2,   A_P2,   A_T0);
         7'd41: u = mk(OP_MUL,  A_T0,   A_D3,   S_DT);
         7'd42: u = mk(OP_ADD,  A_P3,   A_P3,   A_T0);
         7'd43: u = mk(OP_MUL,  A_T0,   A_D4,   S_DT);
         7'd44: u = mk(OP_ADD,  A_P4,   A_P4,   A_T0);
         7'd45: u = mk(OP_MUL,  A_T0,   A_D5,   S_DT);
         7'd46: u = mk(OP_ADD,  A_P5,   A_P5,   A_T0);
         7'd47: u = mk(OP_MUL,  A_T0,   A_D6,   S_DT);
         7'd48: u = mk(OP_ADD,  A_P6,   A_P6,   A_T0);
         7'd49: u = mk(OP_MUL,  A_T0,   A_D5,   S_DT);
         7'd50: u = mk(OP_ADD,  A_P7,   A_P7,   A_T0);
         7'd51: u = mk(OP_MUL,  A_T0,   S_QB,   S_DT);
         7'd52: u = mk(OP_ADD,  A_P8,   A_P8,   A_T0);
         // gain
         7'd53: u = mk(OP_MUL,  A_PC0,  S_C,    A_P0);
         7'd54: u = mk(OP_MUL,  A_PC1,  S_C,    A_P3);
         7'd55: u = mk(OP_MUL,  A_PC2,  S_C,    A_P6);
         7'd56: u = mk(OP_MUL,  A_T0,   S_C,    A_PC0);
         7'd57: u = mk(OP_ADD,  A_E,    S_R,    A_T0);
         7'd58: u = mk(OP_DIV,  A_K0,   A_PC0,  A_E);
         7'd59: u = mk(OP_DIV,  A_K1,   A_PC1,  A_E);
         7'd60: u = mk(OP_DIV,  A_K2,   A_PC2,  A_E);
         // state correction
         7'd61: u = mk(OP_SUB,  A_ERR,  S_Z,    A_POS);
         7'd62: u = mk(OP_MUL,  A_T0,   A_K0,   A_ERR);
         7'd63: u = mk(OP_ADD,  A_POS,  A_POS,  A_T0);
         7'd64: u = mk(OP_MUL,  A_T0,   A_K1,   A_ERR);
         7'd65: u = mk(OP_ADD,  A_VEL,  A_VEL,  A_T0);
         7'd66: u = mk(OP_MUL,  A_T0,   A_K2,   A_ERR);
         7'd67: u = mk(OP_ADD,  A_BIAS, A_BIAS, A_T0);
         // covariance update
         7'd68: u = mk(OP_MUL,  A_T2,   S_C,    A_P1);
         7'd69: u = mk(OP_MUL,  A_T3,   S_C,    A_P2);
         7'd70: u = mk(OP_MUL,  A_T0,   A_K0,   A_PC0);
         7'd71: u = mk(OP_SUB,  A_P0,   A_P0,   A_T0);
         7'd72: u = mk(OP_MUL,  A_T0,   A_K0,   A_T2);
         7'd73: u = mk(OP_SUB,  A_P1,   A_P1,   A_T0);
         7'd74: u = mk(OP_MUL,  A_T0,   A_K0,   A_T3);
         7'd75: u = mk(OP_SUB,  A_P2,   A_P2,   A_T0);
         7'd76: u = mk(OP_MUL,  A_T0,   A_K1,   A_PC0);
         7'd77: u = mk(OP_SUB,  A_P3,   A_P3,   A_T0);
         7'd78: u = mk(OP_MUL,  A_T0,   A_K1,   A_T2);
         7'd79: u = mk(OP_SUB,  A_P4,   A_P4,   A_T0);
         7'd80: u = mk(OP_MUL,  A_T0,   A_K1,   A_T3);
         7'd81: u = mk(OP_SUB,  A_P5,   A_P5,   A_T0);
         7'd82: u = mk(OP_MUL,  A_T0,   A_K2,   A_PC0);
         7'd83: u = mk(OP_SUB,  A_P6,   A_P6,   A_T0);
         7'd84: u = mk(OP_MUL,  A_T0,   A_K2,   A_T2);
         7'd85: u = mk(OP_SUB,  A_P7,   A_P7,   A_T0);
         7'd86: u = mk(OP_MUL,  A_T0,   A_K2,   A_T3);
         7'd87: u = mk(OP_SUB,  A_P8,   A_P8,   A_T0);
         default: u = mk(OP_ADD, A_T0, A_T0, A_T0);
      endcase
      return u;
   endfunction

endpackage

[rtl/position_velocity_bias_kalman_top.sv]
// Channel   Direction  Handshake          Payload
// req_*     in         valid / stall      measured_position, measured_accel
// rsp_*     out        valid / stall      position/velocity/bias estimates, innovation
// csr_*     in         valid / ready      index (3 b), data (48 b)
//
// Each transaction runs 88 microcode steps on one shared ALU: multiplies use
// 5-step 24x24 partial products and divides an 80-step restoring divider
// (three divides per transaction).
// After reset an init pass writes the 12 state words into the scratch RAM;
// req_stall stays high until then. csr writes are taken at any time.
// A finished result waits in the rsp register under stall; the next transaction
// may start meanwhile but is held at its end until that register is free.
`include "position_velocity_bias_kalman_top_defines.svh"

module position_velocity_bias_kalman_top import pvbk_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // request
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [47:0] req_measured_position,
   input  logic [47:0] req_measured_accel,
   // response
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [47:0] rsp_position_estimate,
   output logic [47:0] rsp_velocity_estimate,
   output logic [47:0] rsp_bias_estimate,
   output logic [47:0] rsp_innovation,
   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [47:0] csr_data
);

   // sequencer states
   localparam logic [2:0] ST_INIT  = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_ISSUE = 3'd2;
   localparam logic [2:0] ST_LOAD  = 3'd3;
   localparam logic [2:0] ST_EXEC  = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   // configuration register indexes
   localparam logic [2:0] CSR_QP = 3'd0;
   localparam logic [2:0] CSR_QV = 3'd1;
   localparam logic [2:0] CSR_QB = 3'd2;
   localparam logic [2:0] CSR_R  = 3'd3;
   localparam logic [2:0] CSR_C  = 3'd4;
   localparam logic [2:0] CSR_DT = 3'd5;

   logic [2:0]  state_ff, state_in;
   logic [6:0]  pc_ff, pc_in;
   logic [3:0]  init_cnt_ff, init_cnt_in;

   logic [46:0] qp_ff, qv_ff, qb_ff, r_ff;
   logic [47:0] c_ff;
   logic [32:0] dt_ff;

   logic [47:0] z_ff, accel_ff;
   logic [47:0] pos_out_ff, vel_out_ff, bias_out_ff, err_out_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [47:0] rsp_pos_ff, rsp_vel_ff, rsp_bias_ff, rsp_err_ff;

   ucode_type   uc;
   logic        req_take, rsp_load;

   // scratch RAM, duplicated for two read ports
   logic        rf_we;
   logic [4:0]  rf_waddr;
   logic [47:0] rf_wdata, rf_rdata_a, rf_rdata_b;

   alu_req_type alu_req;
   logic [47:0] alu_a, alu_b, alu_res;
   logic        alu_done;

   assign uc = ucode(pc_ff);
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   // operand source select: scratch RAM or a fixed source
   function automatic logic [47:0] pick(input logic [5:0] sel, input logic [47:0] ram,
                                        input logic [47:0] dt, input logic [47:0] c,
                                        input logic [47:0] qp, input logic [47:0] qv,
                                        input logic [47:0] qb, input logic [47:0] r,
                                        input logic [47:0] z, input logic [47:0] acc);
      logic [47:0] v;
      if (!sel[5]) begin
         v = ram;
      end else begin
         unique case (sel)
            S_DT:    v = dt;
            S_C:     v = c;
            S_QP:    v = qp;
            S_QV:    v = qv;
            S_QB:    v = qb;
            S_R:     v = r;
            S_Z:     v = z;
            S_ACC:   v = acc;
            default: v = 48'd0;
         endcase
      end
      return v;
   endfunction

   assign alu_a = pick(uc.src_a, rf_rdata_a, {15'd0, dt_ff}, c_ff, {1'b0, qp_ff},
                       {1'b0, qv_ff}, {1'b0, qb_ff}, {1'b0, r_ff}, z_ff, accel_ff);
   assign alu_b = pick(uc.src_b, rf_rdata_b, {15'd0, dt_ff}, c_ff, {1'b0, qp_ff},
                       {1'b0, qv_ff}, {1'b0, qb_ff}, {1'b0, r_ff}, z_ff, accel_ff);

   assign alu_req.start = (state_ff == ST_LOAD);
   assign alu_req.op = uc.op;

   // RAM write: initial state during the init pass, ALU results otherwise
   always_comb begin
      if (state_ff == ST_INIT) begin
         rf_we = 1'b1;
         rf_waddr = {1'b0, init_cnt_ff};
         if (init_cnt_ff == A_P0[3:0] || init_cnt_ff == A_P4[3:0]
             || init_cnt_ff == A_P8[3:0]) begin
            rf_wdata = FX_ONE;
         end else begin
            rf_wdata = 48'd0;
         end
      end else begin
         rf_we = (state_ff == ST_EXEC) && alu_done;
         rf_waddr = uc.dst[4:0];
         rf_wdata = alu_res;
      end
   end

   pvbk_ram #(.WIDTH(48), .DEPTH(RF_DEPTH)) u_rf_a (
      .clock   (clock),
      .wr_en   (rf_we),
      .wr_addr (rf_waddr),
      .wr_data (rf_wdata),
      .rd_addr (uc.src_a[4:0]),
      .rd_data (rf_rdata_a)
   );

   pvbk_ram #(.WIDTH(48), .DEPTH(RF_DEPTH)) u_rf_b (
      .clock   (clock),
      .wr_en   (rf_we),
      .wr_addr (rf_waddr),
      .wr_data (rf_wdata),
      .rd_addr (uc.src_b[4:0]),
      .rd_data (rf_rdata_b)
   );

   pvbk_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .req    (alu_req),
      .opa    (alu_a),
      .opb    (alu_b),
      .done   (alu_done),
      .result (alu_res)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      pc_in = pc_ff;
      init_cnt_in = init_cnt_ff;
      unique case (state_ff)
         ST_INIT: begin
            init_cnt_in = init_cnt_ff + 4'd1;
            if (init_cnt_ff == 4'(STATE_WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_take) begin
               pc_in = 7'd0;
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: state_in = ST_LOAD;
         ST_LOAD:  state_in = ST_EXEC;
         ST_EXEC: begin
            if (alu_done) begin
               if (pc_ff == PC_LAST) begin
                  state_in = ST_DONE;
               end else begin
                  pc_in = pc_ff + 7'd1;
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         pc_ff <= 7'd0;
         init_cnt_ff <= 4'd0;
         rsp_valid_ff <= 1'b0;
         qp_ff <= 47'd42949673;
         qv_ff <= 47'd4294967296;
         qb_ff <= 47'd193273528;
         r_ff <= 47'd214748365;
         c_ff <= FX_ONE;
         dt_ff <= 33'd34359738;
      end else begin
         state_ff <= state_in;
         pc_ff <= pc_in;
         init_cnt_ff <= init_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_QP:  qp_ff <= csr_data[46:0];
               CSR_QV:  qv_ff <= csr_data[46:0];
               CSR_QB:  qb_ff <= csr_data[46:0];
               CSR_R:   r_ff <= csr_data[46:0];
               CSR_C:   c_ff <= csr_data;
               CSR_DT:  dt_ff <= csr_data[32:0];
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         z_ff <= req_measured_position;
         accel_ff <= req_measured_accel;
      end
      // shadow copies of the estimates as the microcode writes them
      if (rf_we && state_ff == ST_EXEC) begin
         if (uc.dst == A_POS) begin
            pos_out_ff <= alu_res;
         end
         if (uc.dst == A_VEL) begin
            vel_out_ff <= alu_res;
         end
         if (uc.dst == A_BIAS) begin
            bias_out_ff <= alu_res;
         end
         if (uc.dst == A_ERR) begin
            err_out_ff <= alu_res;
         end
      end
      if (rsp_load) begin
         rsp_pos_ff <= pos_out_ff;
         rsp_vel_ff <= vel_out_ff;
         rsp_bias_ff <= bias_out_ff;
         rsp_err_ff <= err_out_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_position_estimate = rsp_pos_ff;
   assign rsp_velocity_estimate = rsp_vel_ff;
   assign rsp_bias_estimate = rsp_bias_ff;
   assign rsp_innovation = rsp_err_ff;

   // ALU results only land while the sequencer waits for them
   `PVBK_ASSERT_NOW(a_done_in_exec, clock, reset, alu_done, state_ff == ST_EXEC)
   // an accepted transaction starts the microprogram at its first step
   `PVBK_ASSERT_NEXT(a_take_starts, clock, reset, req_take, state_ff == ST_ISSUE && pc_ff == 7'd0)
   // program counter stays inside the microprogram
   `PVBK_ASSERT_NOW(a_pc_range, clock, reset, state_ff != ST_INIT, pc_ff <= PC_LAST)

endmodule

[rtl/pvbk_ram.sv]
module pvbk_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/pvbk_alu.sv]
module pvbk_alu import pvbk_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  alu_req_type req,
   input  logic [47:0] opa,
   input  logic [47:0] opb,
   output logic        done,
   output logic [47:0] result
);

   logic        busy_ff, busy_in;
   logic [2:0]  op_ff, op_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        done_ff, done_in;
   logic [47:0] res_ff, res_in;
   logic        neg_ff, neg_in;
   logic [47:0] ma_ff, ma_in;
   logic [47:0] mb_ff, mb_in;
   logic [47:0] pp_ff, pp_in;
   logic [95:0] acc_ff, acc_in;
   logic [47:0] num_ff, num_in;
   logic [46:0] den_ff, den_in;
   logic [46:0] rem_ff, rem_in;
   logic [48:0] q_ff, q_in;
   logic        sat_ff, sat_in;

   logic [47:0] mag_a, mag_b, simple_res, pp_mul;
   logic [95:0] acc_sum;
   logic [47:0] rem_c;
   logic        qbit;
   logic [49:0] q_cand;

   function automatic logic [47:0] magof(input logic [47:0] v);
      return v[47] ? (~v + 48'd1) : v;
   endfunction

   function automatic logic [47:0] sat_mag(input logic neg, input logic [63:0] m);
      logic [47:0] r;
      if (neg) begin
         r = (m >= 64'h8000_0000_0000) ? FX_MIN : (~m[47:0] + 48'd1);
      end else begin
         r = (m > 64'h7FFF_FFFF_FFFF) ? FX_MAX : m[47:0];
      end
      return r;
   endfunction

   function automatic logic [47:0] sat49(input logic [48:0] s);
      logic [47:0] r;
      if (s[48] != s[47]) begin
         r = s[48] ? FX_MIN : FX_MAX;
      end else begin
         r = s[47:0];
      end
      return r;
   endfunction

   assign mag_a = magof(opa);
   assign mag_b = magof(opb);

   // add, subtract, halve and negate, computed combinationally
   always_comb begin
      logic [48:0] h;
      h = 49'($signed({opa[47], opa}) + $signed({48'd0, opa[47]})) >>> 1;
      unique case (req.op)
         OP_ADD:  simple_res = sat49({opa[47], opa} + {opb[47], opb});
         OP_SUB:  simple_res = sat49({opa[47], opa} - {opb[47], opb});
         OP_HALF: simple_res = {h[48], h[46:0]};
         OP_NEG:  simple_res = (opa == FX_MIN) ? FX_MAX : (~opa + 48'd1);
         default: simple_res = 48'd0;
      endcase
   end

   // 24x24 partial product for the current multiply step
   always_comb begin
      unique case (cnt_ff[1:0])
         2'd0: pp_mul = ma_ff[23:0]  * mb_ff[23:0];
         2'd1: pp_mul = ma_ff[23:0]  * mb_ff[47:24];
         2'd2: pp_mul = ma_ff[47:24] * mb_ff[23:0];
         2'd3: pp_mul = ma_ff[47:24] * mb_ff[47:24];
         default: pp_mul = 48'd0;
      endcase
   end

   // accumulate the partial product registered one step earlier
   always_comb begin
      unique case (cnt_ff[2:0])
         3'd1:    acc_sum = acc_ff + {48'd0, pp_ff};
         3'd2,
         3'd3:    acc_sum = acc_ff + {24'd0, pp_ff, 24'd0};
         3'd4:    acc_sum = acc_ff + {pp_ff, 48'd0};
         default: acc_sum = acc_ff;
      endcase
   end

   // one restoring division step
   always_comb begin
      rem_c = {rem_ff, num_ff[47]};
      qbit = (rem_c >= {1'b0, den_ff});
      q_cand = {q_ff, qbit};
   end

   always_comb begin
      busy_in = busy_ff;
      op_in = op_ff;
      cnt_in = cnt_ff;
      done_in = 1'b0;
      res_in = res_ff;
      neg_in = neg_ff;
      ma_in = ma_ff;
      mb_in = mb_ff;
      pp_in = pp_ff;
      acc_in = acc_ff;
      num_in = num_ff;
      den_in = den_ff;
      rem_in = rem_ff;
      q_in = q_ff;
      sat_in = sat_ff;
      if (busy_ff) begin
         cnt_in = cnt_ff + 7'd1;
         if (op_ff == OP_MUL) begin
            pp_in = pp_mul;
            acc_in = acc_sum;
            if (cnt_ff == 7'd4) begin
               res_in = sat_mag(neg_ff, acc_sum[95:32]);
               done_in = 1'b1;
               busy_in = 1'b0;
            end
         end else begin
            num_in = {num_ff[46:0], 1'b0};
            rem_in = qbit ? 47'(rem_c - {1'b0, den_ff}) : rem_c[46:0];
            sat_in = sat_ff | (q_cand[49:48] != 2'd0);
            q_in = sat_in ? 49'h1_0000_0000_0000 : q_cand[48:0];
            if (cnt_ff == 7'd79) begin
               res_in = sat_mag(neg_ff, {15'd0, q_in});
               done_in = 1'b1;
               busy_in = 1'b0;
            end
         end
      end else if (req.start) begin
         op_in = req.op;
         cnt_in = 7'd0;
         unique case (req.op)
            OP_MUL: begin
               ma_in = mag_a;
               mb_in = mag_b;
               neg_in = opa[47] ^ opb[47];
               acc_in = 96'd0;
               busy_in = 1'b1;
            end
            OP_DIV: begin
               if (opb[47] || opb == 48'd0) begin
                  if (opa[47]) begin
                     res_in = FX_MIN;
                  end else if (opa != 48'd0) begin
                     res_in = FX_MAX;
                  end else begin
                     res_in = 48'd0;
                  end
                  done_in = 1'b1;
               end else begin
                  num_in = mag_a;
                  den_in = opb[46:0];
                  neg_in = opa[47];
                  rem_in = 47'd0;
                  q_in = 49'd0;
                  sat_in = 1'b0;
                  busy_in = 1'b1;
               end
            end
            default: begin
               res_in = simple_res;
               done_in = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= 7'd0;
         op_ff <= OP_ADD;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
         op_ff <= op_in;
      end
      res_ff <= res_in;
      neg_ff <= neg_in;
      ma_ff <= ma_in;
      mb_ff <= mb_in;
      pp_ff <= pp_in;
      acc_ff <= acc_in;
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      q_ff <= q_in;
      sat_ff <= sat_in;
   end

   assign done = done_ff;
   assign result = res_ff;

endmodule

[tb/position_velocity_bias_kalman_top_tb.sv]
`timescale 1ns / 1ps

module position_velocity_bias_kalman_top_tb;

   // csr register map
   typedef enum logic [2:0] {
      REG_NOISE_POS  = 3'd0,
      REG_NOISE_VEL  = 3'd1,
      REG_NOISE_BIAS = 3'd2,
      REG_MEAS_NOISE = 3'd3,
      REG_OBS_GAIN   = 3'd4,
      REG_TIME_STEP  = 3'd5
   } csr_reg_type;

   localparam longint FIX_MAX    = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint FIX_MIN    = -FIX_MAX - 1;
   localparam longint FIX_ONE    = 64'sh0000_0001_0000_0000;
   localparam int     NUM_PHASES = 10;
   localparam int     PHASE_LEN  = 153;
   localparam int     DRAIN_WAIT = 800;       // about one transaction of latency
   localparam longint CYCLE_CAP  = 8_000_000;  // slowest run is well under half of this

   typedef struct {
      logic [47:0] position;
      logic [47:0] accel;
   } sample_type;

   typedef struct {
      logic [47:0] position;
      logic [47:0] velocity;
      logic [47:0] bias;
      logic [47:0] innovation;
   } estimate_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [47:0] req_measured_position;
   logic [47:0] req_measured_accel;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [47:0] rsp_position_estimate;
   logic [47:0] rsp_velocity_estimate;
   logic [47:0] rsp_bias_estimate;
   logic [47:0] rsp_innovation;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [47:0] csr_data;

   position_velocity_bias_kalman_top dut (.*);

   // filter shadow: configuration and state
   longint q_pos, q_vel, q_bias, meas_noise, obs_gain, dt_shadow;
   longint est_pos, est_vel, est_bias;
   longint cov [9];

   sample_type   sample_queue [$];
   estimate_type estimate_queue [$];
   int           fail_count;
   int           rsp_count;
   longint       cycle_count;

   // ---------------------------------------------------------------
   // fixed point helpers (Q16.32 in 48 bits, saturating)
   // ---------------------------------------------------------------
   function automatic longint clip(longint v);
      if (v > FIX_MAX) return FIX_MAX;
      if (v < FIX_MIN) return FIX_MIN;
      return v;
   endfunction

   function automatic longint sext(logic [47:0] v);
      longint r;
      r = {{16{v[47]}}, v};
      return r;
   endfunction

   function automatic logic [127:0] magnitude(longint a);
      logic [127:0] m;
      m = (a < 0) ? 128'(-a) : 128'(a);
      return m;
   endfunction

   function automatic longint apply_sign(bit neg, logic [127:0] m);
      if (neg) begin
         if (m >= (128'd1 << 47)) return FIX_MIN;
         return -longint'(m[63:0]);
      end
      if (m > 128'h7FFF_FFFF_FFFF) return FIX_MAX;
      return longint'(m[63:0]);
   endfunction

   function automatic longint fx_add(longint a, longint b);
      return clip(a + b);
   endfunction

   function automatic longint fx_sub(longint a, longint b);
      return clip(a - b);
   endfunction

   function automatic longint fx_neg(longint a);
      return clip(-a);
   endfunction

   function automatic longint fx_half(longint a);
      return apply_sign(a < 0, magnitude(a) >> 1);
   endfunction

   function automatic longint fx_mul(longint a, longint b);
      logic [127:0] p;
      p = (magnitude(a) * magnitude(b)) >> 32;
      return apply_sign((a < 0) != (b < 0), p);
   endfunction

   // non-positive divisor saturates by sign of the dividend
   function automatic longint fx_div(longint a, longint b);
      logic [127:0] q;
      if (b <= 0) begin
         if (a > 0) return FIX_MAX;
         if (a < 0) return FIX_MIN;
         return 0;
      end
      q = (magnitude(a) << 32) / magnitude(b);
      if (q >= (128'd1 << 48)) q = 128'd1 << 48;
      return apply_sign(a < 0, q);
   endfunction

   function automatic void filter_reset();
      q_pos      = 42949673;
      q_vel      = FIX_ONE;
      q_bias     = 193273528;
      meas_noise = 214748365;
      obs_gain   = FIX_ONE;
      dt_shadow  = 34359738;
      est_pos    = 0;
      est_vel    = 0;
      est_bias   = 0;
      foreach (cov[i]) cov[i] = 0;
      cov[0] = FIX_ONE;
      cov[4] = FIX_ONE;
      cov[8] = FIX_ONE;
   endfunction

   function automatic void csr_shadow_write(csr_reg_type idx, logic [47:0] v);
      case (idx)
         REG_NOISE_POS:  q_pos      = longint'(v[46:0]);
         REG_NOISE_VEL:  q_vel      = longint'(v[46:0]);
         REG_NOISE_BIAS: q_bias     = longint'(v[46:0]);
         REG_MEAS_NOISE: meas_noise = longint'(v[46:0]);
         REG_OBS_GAIN:   obs_gain   = sext(v);
         REG_TIME_STEP:  dt_shadow  = longint'(v[32:0]);
         default: ;
      endcase
   endfunction

   // one filter step: predict, propagate covariance, gain, correct, update
   function automatic estimate_type filter_step(sample_type s);
      longint z, acc, dt, c, corr, pc0, pc1, pc2, e, k0, k1, k2, err, t1, t2;
      longint d [9];
      estimate_type r;
      z   = sext(s.position);
      acc = sext(s.accel);
      dt  = dt_shadow;
      c   = obs_gain;

      corr    = fx_sub(acc, est_bias);
      est_vel = fx_add(est_vel, fx_mul(corr, dt));
      est_pos = fx_add(est_pos, fx_add(fx_half(fx_mul(fx_mul(corr, dt), dt)),
                                       fx_mul(est_vel, dt)));

      d[0] = fx_add(fx_add(fx_add(q_pos, cov[1]), cov[3]),
                    fx_mul(fx_sub(fx_sub(cov[4], fx_half(cov[6])), fx_half(cov[2])), dt));
      d[1] = fx_sub(fx_sub(cov[4], cov[2]), fx_mul(fx_add(fx_half(cov[7]), cov[5]), dt));
      d[2] = fx_sub(cov[5], fx_half(fx_mul(cov[8], dt)));
      d[3] = fx_sub(fx_sub(cov[4], cov[6]), fx_mul(fx_add(cov[7], fx_half(cov[5])), dt));
      d[4] = fx_add(fx_sub(fx_sub(q_vel, cov[7]), cov[5]), fx_mul(cov[8], dt));
      d[5] = fx_neg(cov[8]);
      d[6] = fx_sub(cov[7], fx_half(fx_mul(cov[8], dt)));
      d[7] = fx_neg(cov[8]);
      d[8] = q_bias;
      for (int i = 0; i < 9; i++) cov[i] = fx_add(cov[i], fx_mul(d[i], dt));

      pc0 = fx_mul(c, cov[0]);
      pc1 = fx_mul(c, cov[3]);
      pc2 = fx_mul(c, cov[6]);
      e   = fx_add(meas_noise, fx_mul(c, pc0));
      k0  = fx_div(pc0, e);
      k1  = fx_div(pc1, e);
      k2  = fx_div(pc2, e);

      err      = fx_sub(z, est_pos);
      est_pos  = fx_add(est_pos, fx_mul(k0, err));
      est_vel  = fx_add(est_vel, fx_mul(k1, err));
      est_bias = fx_add(est_bias, fx_mul(k2, err));

      t1 = fx_mul(c, cov[1]);
      t2 = fx_mul(c, cov[2]);
      cov[0] = fx_sub(cov[0], fx_mul(k0, pc0));
      cov[1] = fx_sub(cov[1], fx_mul(k0, t1));
      cov[2] = fx_sub(cov[2], fx_mul(k0, t2));
      cov[3] = fx_sub(cov[3], fx_mul(k1, pc0));
      cov[4] = fx_sub(cov[4], fx_mul(k1, t1));
      cov[5] = fx_sub(cov[5], fx_mul(k1, t2));
      cov[6] = fx_sub(cov[6], fx_mul(k2, pc0));
      cov[7] = fx_sub(cov[7], fx_mul(k2, t1));
      cov[8] = fx_sub(cov[8], fx_mul(k2, t2));

      r.position   = est_pos[47:0];
      r.velocity   = est_vel[47:0];
      r.bias       = est_bias[47:0];
      r.innovation = err[47:0];
      return r;
   endfunction

   // ---------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------
   function automatic logic [47:0] rand48();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[47:0];
   endfunction

   // small signed value, magnitude below 2^bits
   function automatic logic [47:0] rand_small(int bits);
      logic [47:0] m;
      m = rand48() & ((48'd1 << bits) - 1);
      return $urandom_range(0, 1) ? -m : m;
   endfunction

   // mostly plausible sensor data, some full-range noise and rail values
   function automatic sample_type rand_sample();
      sample_type s;
      case ($urandom_range(0, 9))
         8: begin
            s.position = rand48();
            s.accel    = rand48();
         end
         9: begin
            s.position = $urandom_range(0, 1) ? FIX_MAX[47:0] : FIX_MIN[47:0];
            s.accel    = $urandom_range(0, 1) ? FIX_MAX[47:0] : rand_small(40);
         end
         default: begin
            s.position = rand_small($urandom_range(20, 40));
            s.accel    = rand_small($urandom_range(20, 38));
         end
      endcase
      return s;
   endfunction

   // per-phase register values: all zero, all ones, gain rails, zero gain and noise, then random
   function automatic logic [47:0] phase_reg_value(csr_reg_type idx, int ph);
      case (ph)
         1: return 48'd0;
         2: return (idx == REG_OBS_GAIN) ? FIX_MAX[47:0] : 48'hFFFF_FFFF_FFFF;
         3: begin
            if (idx == REG_OBS_GAIN) return FIX_MIN[47:0];
            if (idx == REG_TIME_STEP) return 48'h1_0000_0000;
            return rand_small(34) & 48'h7FFF_FFFF_FFFF;
         end
         4: begin
            // zero gain with zero noise: innovation variance is zero
            if (idx == REG_OBS_GAIN || idx == REG_MEAS_NOISE) return 48'd0;
            return rand_small(34) & 48'h7FFF_FFFF_FFFF;
         end
         default: begin
            if (idx == REG_OBS_GAIN)
               return $urandom_range(0, 2) == 0 ? rand48() : rand_small(34);
            if ($urandom_range(0, 3) == 0) return rand48();
            return rand_small($urandom_range(20, 36)) & 48'h7FFF_FFFF_FFFF;
         end
      endcase
   endfunction

   task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
      fail_count++;
      $display("mismatch on response %0d, %s: got %h expected %h", rsp_count, what, got, want);
   endtask

   // ---------------------------------------------------------------
   // clock and cycle limit
   // ---------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_CAP) begin
         $display("tb: failure");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // request driver: bursts of transactions with random gaps
   // ---------------------------------------------------------------
   int burst_left;
   int gap_left;

   always @(posedge clock) begin
      sample_type s;
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left <= 1;
         gap_left   <= 0;
      end else begin
         // transaction accepted: predict it now, config cannot change under it
         if (req_valid && !req_stall) begin
            s.position = req_measured_position;
            s.accel    = req_measured_accel;
            estimate_queue.push_back(filter_step(s));
            void'(sample_queue.pop_front());
         end
         // pick the next offer; hold steady while stalled
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left  <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (sample_queue.size() > 0) begin
               req_valid             <= 1'b1;
               req_measured_position <= sample_queue[0].position;
               req_measured_accel    <= sample_queue[0].accel;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 12);
                  gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // response monitor and stall pattern
   // ---------------------------------------------------------------
   int  stall_mode;
   int  mode_left;
   int  hold_left;
   bit  hold_done;

   always @(posedge clock) begin
      estimate_type want;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_mode <= 0;
         mode_left  <= 0;
         hold_left  <= 0;
         hold_done  <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (estimate_queue.size() == 0) begin
               fail_count++;
               $display("unexpected response %0d: %h %h %h %h", rsp_count,
                        rsp_position_estimate, rsp_velocity_estimate,
                        rsp_bias_estimate, rsp_innovation);
            end else begin
               want = estimate_queue.pop_front();
               if (rsp_position_estimate !== want.position)
                  report_mismatch("position", rsp_position_estimate, want.position);
               if (rsp_velocity_estimate !== want.velocity)
                  report_mismatch("velocity", rsp_velocity_estimate, want.velocity);
               if (rsp_bias_estimate !== want.bias)
                  report_mismatch("bias", rsp_bias_estimate, want.bias);
               if (rsp_innovation !== want.innovation)
                  report_mismatch("innovation", rsp_innovation, want.innovation);
            end
            rsp_count <= rsp_count + 1;
         end

         // one long hold-off mid-run so the block backs up into req_stall
         if (!hold_done && rsp_count == 200) begin
            hold_done <= 1'b1;
            hold_left <= 5000;
            rsp_stall <= 1'b1;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_stall <= (hold_left > 1);
         end else begin
            if (mode_left == 0) begin
               stall_mode <= $urandom_range(0, 2);
               mode_left  <= $urandom_range(20, 400);
            end else begin
               mode_left <= mode_left - 1;
            end
            case (stall_mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= $urandom_range(0, 1);
               default: rsp_stall <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   // ---------------------------------------------------------------
   // sequencer: reset, directed samples, then config phases
   // ---------------------------------------------------------------
   task automatic csr_write(csr_reg_type idx, logic [47:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      csr_shadow_write(idx, v);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (sample_queue.size() > 0 || req_valid || estimate_queue.size() > 0);
   endtask

   task automatic push(logic [47:0] p, logic [47:0] a);
      sample_type s;
      s.position = p;
      s.accel    = a;
      sample_queue.push_back(s);
   endtask

   initial begin
      fail_count  = 0;
      rsp_count   = 0;
      cycle_count = 0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_measured_position = '0;
      req_measured_accel    = '0;
      rsp_stall   = 1'b0;
      csr_valid   = 1'b0;
      csr_index   = REG_NOISE_POS;
      csr_data    = '0;
      filter_reset();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: rails, zero, one and bit patterns on both fields at reset settings
      push(48'd0, 48'd0);
      push(FIX_MAX[47:0], 48'd0);
      push(FIX_MIN[47:0], 48'd0);
      push(48'd0, FIX_MAX[47:0]);
      push(48'd0, FIX_MIN[47:0]);
      push(FIX_MAX[47:0], FIX_MAX[47:0]);
      push(FIX_MIN[47:0], FIX_MIN[47:0]);
      push(FIX_MAX[47:0], FIX_MIN[47:0]);
      push(FIX_ONE[47:0], FIX_ONE[47:0]);
      push(-FIX_ONE[47:0], 48'd1);
      push(48'hFFFF_FFFF_FFFF, 48'd1);
      push(48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555);
      push(48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA);
      for (int i = 0; i < 7; i++) sample_queue.push_back(rand_sample());
      wait_idle();

      for (int ph = 1; ph <= NUM_PHASES; ph++) begin
         for (int r = REG_NOISE_POS; r <= REG_TIME_STEP; r++)
            csr_write(csr_reg_type'(r), phase_reg_value(csr_reg_type'(r), ph));
         for (int i = 0; i < PHASE_LEN; i++) sample_queue.push_back(rand_sample());
         wait_idle();
      end

      repeat (DRAIN_WAIT) @(posedge clock);
      if (fail_count == 0 && estimate_queue.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
